// ===== rtl/core/pmsmq_pkg.sv =====
// Shared types, constants and register map for the PMSM q-axis model step unit.
package pmsmq_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int RES_W     = 31;
  localparam int INV_L_W   = 31;
  localparam int DT_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_L = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DT    = 2'd2;

  localparam logic [RES_W-1:0]   RES_RST   = 31'd65536;
  localparam logic [INV_L_W-1:0] INV_L_RST = 31'd65536000;
  localparam logic [DT_W-1:0]    DT_RST    = 32'd214748;

  localparam logic OPC_STEP  = 1'b0;
  localparam logic OPC_CLEAR = 1'b1;

  // Motor constants: flux linkage and friction as Q0.32, 1/J as Q16.16.
  localparam logic [31:0] LAMBDA_Q32   = 32'd64424509;
  localparam logic [31:0] FRICTION_Q32 = 32'd429497;
  localparam logic [31:0] INV_J_Q16    = 32'd273066667;
  localparam int          ACC_SHIFT    = 16;
  localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
  localparam int          DB_SCALE     = 1000000;

  // Datapath widths.
  localparam int OPA_W    = 35;
  localparam int OPB_W    = 33;
  localparam int PROD_W   = OPA_W + OPB_W;
  localparam int SUM_W    = 36;
  localparam int MAG_W    = 34;
  localparam int MUL_LO_W = 32 + INV_L_W;
  localparam int WIDE_W   = 66;

  localparam int ANGLE_W   = 19;
  localparam int SPEED_W   = 32;
  localparam int CURRENT_W = 20;
  localparam int STATE_W   = 32;

  typedef struct packed {
    logic              opcode;
    logic signed [31:0] voltage_q;
  } in_t;

  typedef struct packed {
    logic        [ANGLE_W-1:0]   angle_out;
    logic signed [SPEED_W-1:0]   speed_out;
    logic signed [CURRENT_W-1:0] current_out;
  } out_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_LAM_W,
    DP_RES_I,
    DP_NUM,
    DP_MAG_LO,
    DP_DERIV,
    DP_CUR_DT,
    DP_CUR_UPD,
    DP_TQ_I,
    DP_TQ_W,
    DP_TORQUE,
    DP_ACC_J,
    DP_ACC_DT,
    DP_SPD_UPD,
    DP_ANG_DT,
    DP_ANG_UPD
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LAM_W,
    ST_RES_I,
    ST_NUM,
    ST_MAG_LO,
    ST_DERIV,
    ST_CUR_DT,
    ST_CUR_UPD,
    ST_TQ_I,
    ST_TQ_W,
    ST_TORQUE,
    ST_ACC_J,
    ST_ACC_DT,
    ST_SPD_UPD,
    ST_ANG_DT,
    ST_ANG_UPD,
    ST_PUSH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } cmd_t;

endpackage

// ===== rtl/core/pmsm_q_axis_model_step_unit.sv =====
// Top level: surface PMSM q-axis model, one forward Euler step per transaction.
// A step transaction runs through the sequencer states LAM_W to ANG_UPD into PUSH, which
// loads its result into the output register; a clear transaction goes straight to PUSH.
// Either waits in PUSH only while a previous result is still held there. A transaction is
// accepted only in IDLE, so they do not overlap. The nine dependent products of a step
// (back-EMF, resistive drop, 1/L, current*dt, torque, friction, 1/J, acceleration*dt,
// speed*dt) pass one after another through one shared 35x33 multiplier. A result sits in
// its own register, so the next transaction is accepted while it waits.
// Configuration writes take effect at once and are meant for idle periods only.
module pmsm_q_axis_model_step_unit #(
  parameter int FRAC_BITS = pmsmq_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pmsmq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmsmq_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pmsmq_pkg::in_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pmsmq_pkg::out_t                 out_data
);
  import pmsmq_pkg::*;

  cmd_t cmd;

  pmsmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pmsmq_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/pmsmq_dp.sv =====
// Datapath: config registers, model state, shared multiplier and result register.
module pmsmq_dp #(
  parameter int FRAC_BITS = pmsmq_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pmsmq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmsmq_pkg::CFG_W-1:0]        cfg_data,
  input  pmsmq_pkg::in_t                     in_data,
  input  pmsmq_pkg::cmd_t                    cmd,
  output pmsmq_pkg::out_t                    out_data
);
  import pmsmq_pkg::*;

  localparam int IQ_W = FRAC_BITS + 4;

  localparam longint IQ_LIM_L = longint'(5) << FRAC_BITS;
  localparam longint DB_L     = ((longint'(1) << FRAC_BITS) + DB_SCALE / 2) / DB_SCALE;
  localparam longint TWO_PI_L =
    (longint'(TWO_PI_Q29) + (longint'(1) << (28 - FRAC_BITS))) >>> (29 - FRAC_BITS);

  localparam logic [WIDE_W-1:0]       IQ_LIM_WIDE = WIDE_W'(IQ_LIM_L);
  localparam logic [WIDE_W-1:0]       DB_WIDE     = WIDE_W'(DB_L);
  localparam logic signed [OPA_W-1:0] IQ_LIM_A    = OPA_W'(IQ_LIM_L);
  localparam logic signed [SUM_W-1:0] IQ_LIM_S    = SUM_W'(IQ_LIM_L);
  localparam logic signed [SUM_W-1:0] TWO_PI_S    = SUM_W'(TWO_PI_L);
  localparam logic signed [SUM_W-1:0] S32_MAX     = SUM_W'(32'h7fff_ffff);
  localparam logic signed [SUM_W-1:0] S32_MIN     = -S32_MAX - SUM_W'(1);

  logic [RES_W-1:0]   res;
  logic [INV_L_W-1:0] inv_l;
  logic [DT_W-1:0]    dt;

  logic signed [IQ_W-1:0]    iq;
  logic signed [STATE_W-1:0] spd;
  logic signed [STATE_W-1:0] ang;
  logic signed [OPA_W-1:0]   num;
  logic signed [OPA_W-1:0]   tmp;
  logic signed [PROD_W-1:0]  prod;
  out_t                      out_q;

  logic signed [OPA_W-1:0] a_op;
  logic signed [OPB_W-1:0] b_op;
  logic signed [SUM_W-1:0] hi_q32;
  logic signed [SUM_W-1:0] shr_f;
  logic signed [OPA_W-1:0] acc_q;

  logic                    num_neg;
  logic [OPA_W-1:0]        num_abs;
  logic [MAG_W-1:0]        mag;
  logic [OPB_W-1:0]        mag_hi_prod;
  logic [WIDE_W-1:0]       wide;
  logic [WIDE_W-1:0]       dq_full;
  logic signed [OPA_W-1:0] dq;
  logic signed [OPA_W-1:0] d_val;

  logic signed [SUM_W-1:0] cur_sum;
  logic signed [SUM_W-1:0] cur_sat;
  logic signed [SUM_W-1:0] spd_sum;
  logic signed [SUM_W-1:0] spd_sat;
  logic signed [SUM_W-1:0] ang_sum;
  logic signed [SUM_W-1:0] ang_wrap;
  logic signed [SUM_W-1:0] ang_sat;

  // Floor-shifted views of the product register.
  assign hi_q32 = prod[PROD_W-1:32];
  assign shr_f  = prod[FRAC_BITS+SUM_W-1:FRAC_BITS];
  assign acc_q  = prod[ACC_SHIFT+OPA_W-1:ACC_SHIFT];

  // Current derivative magnitude, saturated to the current limit and zeroed below the dead band, then signed.
  always_comb begin
    num_neg     = num[OPA_W-1];
    num_abs     = num_neg ? OPA_W'(-num) : OPA_W'(num);
    mag         = num_abs[MAG_W-1:0];
    mag_hi_prod = OPB_W'(mag[MAG_W-1:32]) * OPB_W'(inv_l);
    wide        = WIDE_W'(prod[MUL_LO_W-1:0]) + {1'b0, mag_hi_prod, 32'b0};
    dq_full     = wide >> FRAC_BITS;
    if (dq_full > IQ_LIM_WIDE) begin
      dq = IQ_LIM_A;
    end else if (dq_full < DB_WIDE) begin
      dq = '0;
    end else begin
      dq = $signed(dq_full[OPA_W-1:0]);
    end
    d_val = num_neg ? -dq : dq;
  end

  always_comb begin
    cur_sum = SUM_W'(iq) + hi_q32;
    if (cur_sum > IQ_LIM_S) begin
      cur_sat = IQ_LIM_S;
    end else if (cur_sum < -IQ_LIM_S) begin
      cur_sat = -IQ_LIM_S;
    end else begin
      cur_sat = cur_sum;
    end

    spd_sum = SUM_W'(spd) + hi_q32;
    if (spd_sum > S32_MAX) begin
      spd_sat = S32_MAX;
    end else if (spd_sum < S32_MIN) begin
      spd_sat = S32_MIN;
    end else begin
      spd_sat = spd_sum;
    end

    ang_sum = SUM_W'(ang) + hi_q32;
    if (ang_sum >= TWO_PI_S) begin
      ang_wrap = ang_sum - TWO_PI_S;
    end else if (ang_sum < 0) begin
      ang_wrap = ang_sum + TWO_PI_S;
    end else begin
      ang_wrap = ang_sum;
    end
    if (ang_wrap > S32_MAX) begin
      ang_sat = S32_MAX;
    end else if (ang_wrap < S32_MIN) begin
      ang_sat = S32_MIN;
    end else begin
      ang_sat = ang_wrap;
    end
  end

  // Operand select for the shared multiplier.
  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd.op)
      DP_LAM_W: begin
        a_op = OPA_W'(spd);
        b_op = $signed({1'b0, LAMBDA_Q32});
      end
      DP_RES_I: begin
        a_op = OPA_W'(iq);
        b_op = $signed({2'b0, res});
      end
      DP_MAG_LO: begin
        a_op = $signed({3'b0, mag[31:0]});
        b_op = $signed({2'b0, inv_l});
      end
      DP_CUR_DT: begin
        a_op = tmp;
        b_op = $signed({1'b0, dt});
      end
      DP_TQ_I: begin
        a_op = OPA_W'(iq);
        b_op = $signed({1'b0, LAMBDA_Q32});
      end
      DP_TQ_W: begin
        a_op = OPA_W'(spd);
        b_op = $signed({1'b0, FRICTION_Q32});
      end
      DP_ACC_J: begin
        a_op = tmp;
        b_op = $signed({1'b0, INV_J_Q16});
      end
      DP_ACC_DT: begin
        a_op = acc_q;
        b_op = $signed({1'b0, dt});
      end
      DP_ANG_DT: begin
        a_op = OPA_W'(spd);
        b_op = $signed({1'b0, dt});
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res   <= RES_RST;
      inv_l <= INV_L_RST;
      dt    <= DT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RES:   res   <= cfg_data[RES_W-1:0];
        REG_INV_L: inv_l <= cfg_data[INV_L_W-1:0];
        REG_DT:    dt    <= cfg_data[DT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iq  <= '0;
      spd <= '0;
      ang <= '0;
    end else begin
      case (cmd.op)
        DP_CLEAR: begin
          iq  <= '0;
          spd <= '0;
          ang <= '0;
        end
        DP_CUR_UPD: iq  <= IQ_W'(cur_sat);
        DP_SPD_UPD: spd <= STATE_W'(spd_sat);
        DP_ANG_UPD: ang <= STATE_W'(ang_sat);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD:   num <= OPA_W'(in_data.voltage_q);
      DP_RES_I:  num <= num - OPA_W'(hi_q32);
      DP_NUM:    num <= num - OPA_W'(shr_f);
      DP_DERIV:  tmp <= d_val;
      DP_TQ_W:   tmp <= OPA_W'(hi_q32);
      DP_TORQUE: tmp <= tmp - OPA_W'(hi_q32);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_q.angle_out   <= ang[ANGLE_W-1:0];
      out_q.speed_out   <= spd;
      out_q.current_out <= CURRENT_W'(iq);
    end
  end

  assign out_data = out_q;

endmodule

// ===== rtl/core/pmsmq_ctrl.sv =====
// Sequencer for one model step or clear, and the result register handshake.
module pmsmq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_opcode,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output pmsmq_pkg::cmd_t cmd
);
  import pmsmq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;
  logic        out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.op       = DP_NOP;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OPC_CLEAR) begin
            cmd.op     = DP_CLEAR;
            state_next = ST_PUSH;
          end else begin
            cmd.op     = DP_LOAD;
            state_next = ST_LAM_W;
          end
        end
      end
      ST_LAM_W: begin
        cmd.op     = DP_LAM_W;
        state_next = ST_RES_I;
      end
      ST_RES_I: begin
        cmd.op     = DP_RES_I;
        state_next = ST_NUM;
      end
      ST_NUM: begin
        cmd.op     = DP_NUM;
        state_next = ST_MAG_LO;
      end
      ST_MAG_LO: begin
        cmd.op     = DP_MAG_LO;
        state_next = ST_DERIV;
      end
      ST_DERIV: begin
        cmd.op     = DP_DERIV;
        state_next = ST_CUR_DT;
      end
      ST_CUR_DT: begin
        cmd.op     = DP_CUR_DT;
        state_next = ST_CUR_UPD;
      end
      ST_CUR_UPD: begin
        cmd.op     = DP_CUR_UPD;
        state_next = ST_TQ_I;
      end
      ST_TQ_I: begin
        cmd.op     = DP_TQ_I;
        state_next = ST_TQ_W;
      end
      ST_TQ_W: begin
        cmd.op     = DP_TQ_W;
        state_next = ST_TORQUE;
      end
      ST_TORQUE: begin
        cmd.op     = DP_TORQUE;
        state_next = ST_ACC_J;
      end
      ST_ACC_J: begin
        cmd.op     = DP_ACC_J;
        state_next = ST_ACC_DT;
      end
      ST_ACC_DT: begin
        cmd.op     = DP_ACC_DT;
        state_next = ST_SPD_UPD;
      end
      ST_SPD_UPD: begin
        cmd.op     = DP_SPD_UPD;
        state_next = ST_ANG_DT;
      end
      ST_ANG_DT: begin
        cmd.op     = DP_ANG_DT;
        state_next = ST_ANG_UPD;
      end
      ST_ANG_UPD: begin
        cmd.op     = DP_ANG_UPD;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== rtl/core/pmsmq_checker.sv =====
// Port-level checks for the PMSM q-axis model step unit, bound to the top level.
module pmsmq_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input pmsmq_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input pmsmq_pkg::out_t out_data
);
  import pmsmq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted while another is in progress");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.opcode == OPC_CLEAR) && !out_valid |-> ##2
      (out_valid && (out_data.angle_out == '0) && (out_data.speed_out == '0) &&
       (out_data.current_out == '0)))
    else $error("clear transaction did not report a zero state");

endmodule

bind pmsm_q_axis_model_step_unit pmsmq_checker u_pmsmq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_pmsm_q_axis_model_step_unit.sv =====
// Self-checking testbench for the PMSM q-axis model step unit with a bit-exact predictor.
`timescale 1ns / 100ps

module tb_pmsm_q_axis_model_step_unit;
  import pmsmq_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint IQ_LIMIT   = longint'(5) << FRAC;
  localparam longint DEAD_BAND  = ((longint'(1) << FRAC) + DB_SCALE / 2) / DB_SCALE;
  localparam longint TWO_PI_FX  =
    (longint'(TWO_PI_Q29) + (longint'(1) << (28 - FRAC))) >>> (29 - FRAC);
  localparam longint STATE_MIN  = -64'sd2147483648;
  localparam longint STATE_MAX  = 64'sd2147483647;

  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 130;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;

  pmsm_q_axis_model_step_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Register shadow and motor state estimate.
  logic [RES_W-1:0]   res_r   = RES_RST;
  logic [INV_L_W-1:0] inv_l_r = INV_L_RST;
  logic [DT_W-1:0]    dt_r    = DT_RST;
  longint iq_est    = 0;
  longint speed_est = 0;
  longint angle_est = 0;

  in_t  pending[$];
  out_t expected_q[$];
  out_t want;
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned idle_cycles  = 0;
  int          send_gap     = 0;
  int          recv_gap     = 0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;
  bit          quiet        = 1'b0;

  function automatic longint mul_q32(longint a, logic [31:0] b);
    longint hi, lo;
    hi = longint'(b[31:16]);
    lo = longint'(b[15:0]);
    return (a * hi + ((a * lo) >>> 16)) >>> 16;
  endfunction

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic out_t advance_motor(in_t item);
    longint      num, d, torque, acc, ang;
    logic [63:0] mag, dmag;
    logic [95:0] prod;
    logic        neg;
    out_t        res;
    if (item.opcode == OPC_CLEAR) begin
      iq_est = 0;
      speed_est = 0;
      angle_est = 0;
    end else begin
      num = longint'(item.voltage_q) - ((longint'(res_r) * iq_est) >>> FRAC)
            - mul_q32(speed_est, LAMBDA_Q32);
      neg = num < 0;
      mag = neg ? 64'(-num) : 64'(num);
      prod = 96'(mag) * 96'(inv_l_r);
      if (prod > 96'(64'hFFFF_FFFF_FFFF_FFFF)) dmag = 64'(IQ_LIMIT);
      else dmag = prod[63:0] >> FRAC;
      if (dmag < 64'(DEAD_BAND)) dmag = '0;
      if (dmag > 64'(IQ_LIMIT)) dmag = 64'(IQ_LIMIT);
      d = neg ? -longint'(dmag) : longint'(dmag);
      iq_est = clamp_range(iq_est + mul_q32(d, dt_r), -IQ_LIMIT, IQ_LIMIT);

      torque = mul_q32(iq_est, LAMBDA_Q32) - mul_q32(speed_est, FRICTION_Q32);
      acc = (torque * longint'(INV_J_Q16)) >>> ACC_SHIFT;
      speed_est = clamp_range(speed_est + mul_q32(acc, dt_r), STATE_MIN, STATE_MAX);

      ang = angle_est + mul_q32(speed_est, dt_r);
      if (ang >= TWO_PI_FX) ang -= TWO_PI_FX;
      else if (ang < 0) ang += TWO_PI_FX;
      angle_est = clamp_range(ang, STATE_MIN, STATE_MAX);
    end
    res.angle_out = angle_est[ANGLE_W-1:0];
    res.speed_out = speed_est[SPEED_W-1:0];
    res.current_out = iq_est[CURRENT_W-1:0];
    return res;
  endfunction

  function automatic void queue_item(logic opc, logic [31:0] v);
    in_t it;
    it.opcode = opc;
    it.voltage_q = v;
    pending.push_back(it);
    queued_cnt++;
  endfunction

  function automatic logic [31:0] pick_cfg(logic [31:0] dflt);
    case ($urandom_range(0, 4))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return dflt;
      3: return $urandom_range(1, 32'h00FF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_RES:   res_r = val[RES_W-1:0];
      REG_INV_L: inv_l_r = val[INV_L_W-1:0];
      REG_DT:    dt_r = val[DT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (!(accepted_cnt == queued_cnt && expected_q.size() == 0)) @(posedge clk);
  endtask

  // Driver: presents pending transactions, predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(advance_motor(in_data));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending.size() > 0) begin
          in_data <= pending.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results in order and drives backpressure.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: angle %0d speed %0d current %0d",
                 out_data.angle_out, out_data.speed_out, out_data.current_out);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.angle_out !== want.angle_out) begin
            $error("angle_out: expected %0d, actual %0d", want.angle_out, out_data.angle_out);
            errors++;
          end
          if (out_data.speed_out !== want.speed_out) begin
            $error("speed_out: expected %0d, actual %0d", want.speed_out, out_data.speed_out);
            errors++;
          end
          if (out_data.current_out !== want.current_out) begin
            $error("current_out: expected %0d, actual %0d",
                   want.current_out, out_data.current_out);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        // long hold-off so the unit backs up and stalls its input
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        recv_gap <= $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          drive;
    int          run_left;
    logic [31:0] v;
    drive = 0;
    run_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Default registers: clear, zero, voltage extremes.
    queue_item(OPC_CLEAR, 32'h0);
    queue_item(OPC_STEP, 32'h0);
    repeat (3) queue_item(OPC_STEP, 32'h7FFF_FFFF);
    repeat (2) queue_item(OPC_STEP, 32'h8000_0000);
    queue_item(OPC_STEP, 32'h0);
    queue_item(OPC_CLEAR, 32'hFFFF_FFFF);
    queue_item(OPC_STEP, 32'h1);
    drain();

    // Oversized writes, max dt: derivative overflow, speed saturation, angle wrap.
    write_reg(REG_RES, 32'hFFFF_FFFF);
    write_reg(REG_INV_L, 32'hFFFF_FFFF);
    write_reg(REG_DT, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, $urandom());
    repeat (4) queue_item(OPC_STEP, 32'h7FFF_FFFF);
    repeat (4) queue_item(OPC_STEP, 32'h8000_0000);
    queue_item(OPC_CLEAR, 32'h0);
    repeat (2) queue_item(OPC_STEP, 32'h8000_0000);
    drain();

    // Zero 1/L, then zero dt.
    write_reg(REG_INV_L, 32'h0);
    write_reg(REG_DT, DT_RST);
    repeat (2) queue_item(OPC_STEP, 32'h7FFF_FFFF);
    drain();
    write_reg(REG_INV_L, INV_L_RST);
    write_reg(REG_DT, 32'h0);
    repeat (2) queue_item(OPC_STEP, 32'h7FFF_FFFF);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet = (phase == 3) || (phase == RANDOM_PHASES - 1);
      if (phase == 0) begin
        write_reg(REG_RES, 32'd1);
        write_reg(REG_INV_L, 32'd1);
        write_reg(REG_DT, 32'd1);
      end else if (phase == 1) begin
        write_reg(REG_RES, 32'h7FFF_FFFF);
        write_reg(REG_INV_L, 32'h7FFF_FFFF);
        write_reg(REG_DT, 32'hFFFF_FFFF);
      end else if (phase == RANDOM_PHASES - 1) begin
        write_reg(REG_RES, RES_RST);
        write_reg(REG_INV_L, INV_L_RST);
        write_reg(REG_DT, DT_RST);
      end else begin
        write_reg(REG_RES, pick_cfg(RES_RST));
        write_reg(REG_INV_L, pick_cfg(INV_L_RST));
        write_reg(REG_DT, pick_cfg(DT_RST));
        if ($urandom_range(0, 1) == 0) write_reg(REG_UNUSED, $urandom());
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          // sustained drive level so current and speed build up
          drive = int'($urandom_range(0, 48 * 65536)) - 24 * 65536;
          run_left = $urandom_range(5, 40);
        end
        run_left--;
        case ($urandom_range(0, 7))
          0: v = $urandom();
          1: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: v = drive + int'($urandom_range(0, 131072)) - 65536;
        endcase
        if ($urandom_range(0, 19) == 0) queue_item(OPC_CLEAR, v);
        else queue_item(OPC_STEP, v);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
